[src/tbg_pkg.sv]
// ----------------------------------------------------------------------------
// tbg_pkg: shared types and constants for the touch button gesture block
// Transaction payloads, field codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tbg_pkg;

   localparam int TIME_BITS = 32;
   localparam int CFG_BITS  = 16;

   localparam logic [TIME_BITS-1:0] STAGE_STEP_MS = TIME_BITS'(1000);

   localparam logic [CFG_BITS-1:0] IDLE_EXPIRE_RESET  = CFG_BITS'(1500);
   localparam logic [CFG_BITS-1:0] REBOOT_HOLD_RESET  = CFG_BITS'(5000);
   localparam logic [CFG_BITS-1:0] FACTORY_HOLD_RESET = CFG_BITS'(15000);

   localparam logic [1:0] TAP_MAX    = 2'd3;
   localparam logic [1:0] TAP_DOUBLE = 2'd2;

   // input codes
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_PRESS   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [1:0] BTN_A       = 2'd0;
   localparam logic [1:0] BTN_B       = 2'd1;
   localparam logic [1:0] BTN_CENTER  = 2'd2;
   localparam logic [1:0] BTN_UNSUPP  = 2'd3;

   // output codes
   localparam logic [1:0] SOCKET_NONE = 2'd0;
   localparam logic [1:0] LED_NONE    = 2'd0;
   localparam logic [1:0] LED_ON      = 2'd1;
   localparam logic [1:0] LED_OFF     = 2'd2;
   localparam logic [1:0] FLASH_NONE  = 2'd0;
   localparam logic [1:0] FLASH_ONCE  = 2'd1;
   localparam logic [1:0] FLASH_TWICE = 2'd2;
   localparam logic [1:0] COLOR_NONE  = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_YELLOW = 2'd2;

   localparam logic [1:0] STAGE_IDLE    = 2'd0;
   localparam logic [1:0] STAGE_ARMED   = 2'd1;
   localparam logic [1:0] STAGE_REBOOT  = 2'd2;
   localparam logic [1:0] STAGE_FACTORY = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_IDLE_EXPIRE  = 2'd0;
   localparam logic [1:0] CSR_REBOOT_HOLD  = 2'd1;
   localparam logic [1:0] CSR_FACTORY_HOLD = 2'd2;
   localparam logic [1:0] CSR_BUTTONS_EN   = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic [1:0]           button;
      logic [TIME_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] socket_toggle;
      logic       reboot_request;
      logic       reenable_buttons;
      logic       factory_reset_request;
      logic       reboot_armed_event;
      logic       factory_armed_event;
      logic [1:0] status_led_change;
      logic [1:0] status_flash_count;
      logic [1:0] wifi_flash_color;
      logic [1:0] reset_stage;
   } rsp_type;

endpackage

[src/touch_button_gesture_fsm.sv]
// ----------------------------------------------------------------------------
// touch_button_gesture_fsm: touch button gesture recognizer
// Double tap, triple tap and long hold detection on buttons A, B and center.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per tick, press or release, with the
//   current millisecond time. rsp_* returns exactly one result transaction
//   per request, in order. csr_* writes the four configuration registers
//   (idle expire, reboot hold, factory hold, buttons enabled); write only
//   while no transaction is in flight.
// Pipeline and throughput:
//   A request lands in an input register, is evaluated combinationally against
//   the gesture state and the result is held in an output register, which
//   drives rsp_valid. One transaction per cycle is sustained while rsp_stall
//   is low; the state update is a single subtract-and-compare pass.
// Stall:
//   While rsp_stall holds a result, one more request can wait in the input
//   register; after that req_stall is raised until the result is taken.
// Reset:
//   Synchronous, active high. Clears the gesture state, both pipeline
//   valids and loads the register defaults (1500, 5000, 15000, enabled).
// ----------------------------------------------------------------------------
module touch_button_gesture_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbg_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [tbg_pkg::CFG_BITS-1:0] csr_wdata
);

   // configuration
   logic [tbg_pkg::CFG_BITS-1:0] idle_expire_ff;
   logic [tbg_pkg::CFG_BITS-1:0] reboot_hold_ff;
   logic [tbg_pkg::CFG_BITS-1:0] factory_hold_ff;
   logic                         buttons_en_ff, buttons_en_in;

   // pipeline
   logic             in_valid_ff;
   tbg_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   tbg_pkg::rsp_type out_data_ff, out_data_in;
   logic             advance, fire, req_take;

   // gesture state
   logic                          pressed_ff, pressed_in;
   logic                          active_valid_ff, active_valid_in;
   logic [1:0]                    active_button_ff, active_button_in;
   logic [1:0]                    tap_count_ff, tap_count_in;
   logic [1:0]                    stage_ff, stage_in;
   logic [tbg_pkg::TIME_BITS-1:0] press_stamp_ff, press_stamp_in;

   logic [tbg_pkg::TIME_BITS-1:0] diff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign diff = in_data_ff.now_ms - press_stamp_ff;

   always_comb begin
      logic ev_ok;
      logic same;
      logic [1:0] btn;
      ev_ok            = 1'b0;
      same             = 1'b0;
      btn              = in_data_ff.button;
      out_data_in      = '0;
      pressed_in       = pressed_ff;
      active_valid_in  = active_valid_ff;
      active_button_in = active_button_ff;
      tap_count_in     = tap_count_ff;
      stage_in         = stage_ff;
      press_stamp_in   = press_stamp_ff;
      buttons_en_in    = buttons_en_ff;

      // timers run against the time before the event
      if (pressed_ff) begin
         if (active_valid_ff && active_button_ff == tbg_pkg::BTN_CENTER) begin
            if (stage_ff == tbg_pkg::STAGE_ARMED &&
                diff >= tbg_pkg::TIME_BITS'(reboot_hold_ff)) begin
               stage_in                       = tbg_pkg::STAGE_REBOOT;
               out_data_in.reboot_armed_event = 1'b1;
               out_data_in.wifi_flash_color   = tbg_pkg::COLOR_GREEN;
               out_data_in.status_flash_count = tbg_pkg::FLASH_ONCE;
               press_stamp_in                 = press_stamp_ff + tbg_pkg::STAGE_STEP_MS;
            end else if (stage_ff == tbg_pkg::STAGE_REBOOT &&
                         diff >= tbg_pkg::TIME_BITS'(factory_hold_ff)) begin
               stage_in                        = tbg_pkg::STAGE_FACTORY;
               out_data_in.factory_armed_event = 1'b1;
               out_data_in.wifi_flash_color    = tbg_pkg::COLOR_YELLOW;
               out_data_in.status_flash_count  = tbg_pkg::FLASH_TWICE;
               press_stamp_in                  = press_stamp_ff + tbg_pkg::STAGE_STEP_MS;
            end
         end
      end else if (diff >= tbg_pkg::TIME_BITS'(idle_expire_ff)) begin
         active_valid_in = 1'b0;
      end

      ev_ok = (in_data_ff.action == tbg_pkg::ACT_PRESS ||
               in_data_ff.action == tbg_pkg::ACT_RELEASE) &&
              btn != tbg_pkg::BTN_UNSUPP &&
              (buttons_en_ff || btn == tbg_pkg::BTN_CENTER);
      same  = active_valid_in && active_button_ff == btn;

      if (ev_ok) begin
         if (in_data_ff.action == tbg_pkg::ACT_PRESS) begin
            if (!pressed_ff) begin
               pressed_in                    = 1'b1;
               out_data_in.status_led_change = tbg_pkg::LED_ON;
            end
            if (!same) begin
               active_valid_in  = 1'b1;
               active_button_in = btn;
               tap_count_in     = '0;
               stage_in         = tbg_pkg::STAGE_IDLE;
            end
            press_stamp_in = in_data_ff.now_ms;
         end else begin
            if (pressed_ff) begin
               pressed_in                    = 1'b0;
               out_data_in.status_led_change = tbg_pkg::LED_OFF;
            end
            if (!same) begin
               active_valid_in = 1'b0;
            end else begin
               if (tap_count_ff != tbg_pkg::TAP_MAX) begin
                  tap_count_in = tap_count_ff + 2'd1;
               end
               if (btn != tbg_pkg::BTN_CENTER) begin
                  if (tap_count_in == tbg_pkg::TAP_DOUBLE) begin
                     out_data_in.socket_toggle = btn + 2'd1;
                     active_valid_in           = 1'b0;
                  end
               end else begin
                  unique case (stage_in)
                     tbg_pkg::STAGE_IDLE: begin
                        if (tap_count_in == tbg_pkg::TAP_MAX) begin
                           stage_in = tbg_pkg::STAGE_ARMED;
                        end
                     end
                     tbg_pkg::STAGE_ARMED: begin
                        active_valid_in = 1'b0;
                     end
                     tbg_pkg::STAGE_REBOOT: begin
                        active_valid_in            = 1'b0;
                        out_data_in.reboot_request = 1'b1;
                        if (!buttons_en_ff) begin
                           out_data_in.reenable_buttons = 1'b1;
                           buttons_en_in                = 1'b1;
                        end
                     end
                     default: begin
                        active_valid_in                   = 1'b0;
                        out_data_in.factory_reset_request = 1'b1;
                     end
                  endcase
               end
            end
         end
      end

      out_data_in.reset_stage = stage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         idle_expire_ff   <= tbg_pkg::IDLE_EXPIRE_RESET;
         reboot_hold_ff   <= tbg_pkg::REBOOT_HOLD_RESET;
         factory_hold_ff  <= tbg_pkg::FACTORY_HOLD_RESET;
         buttons_en_ff    <= 1'b1;
         pressed_ff       <= 1'b0;
         active_valid_ff  <= 1'b0;
         active_button_ff <= tbg_pkg::BTN_A;
         tap_count_ff     <= '0;
         stage_ff         <= tbg_pkg::STAGE_IDLE;
         press_stamp_ff   <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_data;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (fire) begin
            out_valid_ff     <= 1'b1;
            out_data_ff      <= out_data_in;
            pressed_ff       <= pressed_in;
            active_valid_ff  <= active_valid_in;
            active_button_ff <= active_button_in;
            tap_count_ff     <= tap_count_in;
            stage_ff         <= stage_in;
            press_stamp_ff   <= press_stamp_in;
            buttons_en_ff    <= buttons_en_in;
         end else if (advance) begin
            out_valid_ff <= 1'b0;
         end

         // the user must write only while idle so writes never collide with fire; the block does not enforce it
         if (csr_wr_en) begin
            unique case (csr_index)
               tbg_pkg::CSR_IDLE_EXPIRE:  idle_expire_ff  <= csr_wdata;
               tbg_pkg::CSR_REBOOT_HOLD:  reboot_hold_ff  <= csr_wdata;
               tbg_pkg::CSR_FACTORY_HOLD: factory_hold_ff <= csr_wdata;
               default:                   buttons_en_ff   <= csr_wdata[0];
            endcase
         end
      end
   end

endmodule

[src/tbg_checker.sv]
// ----------------------------------------------------------------------------
// tbg_checker: port-level checks for the touch button gesture block
// Result consistency and output hold under stall, bound to the top level.
// ----------------------------------------------------------------------------
module tbg_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tbg_pkg::rsp_type rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a press of another button in the same transaction may drop the stage
   a_reboot_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reboot_armed_event |->
         rsp_data.status_flash_count == tbg_pkg::FLASH_ONCE &&
         rsp_data.wifi_flash_color == tbg_pkg::COLOR_GREEN)
      else $error("reboot advance without single green flash");

   a_factory_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.factory_armed_event |->
         rsp_data.status_flash_count == tbg_pkg::FLASH_TWICE &&
         !rsp_data.reboot_armed_event)
      else $error("factory advance without double flash");

   a_reboot_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reboot_request |->
         rsp_data.reset_stage == tbg_pkg::STAGE_REBOOT &&
         !rsp_data.factory_reset_request)
      else $error("reboot request outside reboot stage");

   a_reenable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reenable_buttons |-> rsp_data.reboot_request)
      else $error("buttons re-enabled without reboot");

endmodule

bind touch_button_gesture_fsm tbg_checker u_tbg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/touch_button_gesture_checker.sv]
// ----------------------------------------------------------------------------
// touch_button_gesture_checker: gesture predictor and result scoreboard
// Watches the request, result and register ports of the gesture block, keeps
// its own copy of the gesture state and registers, predicts one result per
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module touch_button_gesture_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  tbg_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  tbg_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [tbg_pkg::CFG_BITS-1:0] csr_wdata,
   output int                           mismatch_count,
   output int                           pending,
   output int                           results_checked,
   output int                           gestures_seen
);

   import tbg_pkg::*;

   // register copies
   logic [CFG_BITS-1:0] idle_expire;
   logic [CFG_BITS-1:0] reboot_hold;
   logic [CFG_BITS-1:0] factory_hold;
   logic                buttons_en;

   // gesture state copies
   logic                 held;
   logic                 active_valid;
   logic [1:0]           active_btn;
   logic [1:0]           tap_count;
   logic [1:0]           gesture_stage;
   logic [TIME_BITS-1:0] press_stamp;

   rsp_type expected_gestures[$];
   rsp_type want;

   function automatic rsp_type evaluate_gesture(input req_type item);
      rsp_type              res;
      logic [TIME_BITS-1:0] elapsed;
      logic                 same_btn;
      res = '0;
      elapsed = item.now_ms - press_stamp;

      // timers run against the stamp before the event
      if (held) begin
         if (active_valid && active_btn == BTN_CENTER) begin
            if (gesture_stage == STAGE_ARMED && elapsed >= reboot_hold) begin
               gesture_stage = STAGE_REBOOT;
               res.reboot_armed_event = 1'b1;
               res.status_flash_count = FLASH_ONCE;
               res.wifi_flash_color = COLOR_GREEN;
               press_stamp = press_stamp + STAGE_STEP_MS;
            end else if (gesture_stage == STAGE_REBOOT && elapsed >= factory_hold) begin
               gesture_stage = STAGE_FACTORY;
               res.factory_armed_event = 1'b1;
               res.status_flash_count = FLASH_TWICE;
               res.wifi_flash_color = COLOR_YELLOW;
               press_stamp = press_stamp + STAGE_STEP_MS;
            end
         end
      end else if (elapsed >= idle_expire) begin
         active_valid = 1'b0;
      end

      if ((item.action == ACT_PRESS || item.action == ACT_RELEASE) &&
          item.button != BTN_UNSUPP && (buttons_en || item.button == BTN_CENTER)) begin
         same_btn = active_valid && active_btn == item.button;
         if (item.action == ACT_PRESS) begin
            if (!held) begin
               held = 1'b1;
               res.status_led_change = LED_ON;
            end
            if (!same_btn) begin
               active_valid = 1'b1;
               active_btn = item.button;
               tap_count = 2'd0;
               gesture_stage = STAGE_IDLE;
            end
            press_stamp = item.now_ms;
         end else begin
            if (held) begin
               held = 1'b0;
               res.status_led_change = LED_OFF;
            end
            if (!same_btn) begin
               // release of some other button: forget the active one
               active_valid = 1'b0;
            end else begin
               if (tap_count < TAP_MAX)
                  tap_count = tap_count + 2'd1;
               if (item.button != BTN_CENTER) begin
                  if (tap_count == TAP_DOUBLE) begin
                     res.socket_toggle = item.button + 2'd1;
                     active_valid = 1'b0;
                  end
               end else begin
                  case (gesture_stage)
                     STAGE_IDLE: begin
                        if (tap_count == TAP_MAX)
                           gesture_stage = STAGE_ARMED;
                     end
                     STAGE_ARMED: begin
                        active_valid = 1'b0;
                     end
                     STAGE_REBOOT: begin
                        active_valid = 1'b0;
                        res.reboot_request = 1'b1;
                        if (!buttons_en) begin
                           res.reenable_buttons = 1'b1;
                           buttons_en = 1'b1;
                        end
                     end
                     default: begin
                        active_valid = 1'b0;
                        res.factory_reset_request = 1'b1;
                     end
                  endcase
               end
            end
         end
      end

      res.reset_stage = gesture_stage;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [1:0] want_v,
                              input logic [1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_expire = IDLE_EXPIRE_RESET;
         reboot_hold = REBOOT_HOLD_RESET;
         factory_hold = FACTORY_HOLD_RESET;
         buttons_en = 1'b1;
         held = 1'b0;
         active_valid = 1'b0;
         active_btn = BTN_A;
         tap_count = 2'd0;
         gesture_stage = STAGE_IDLE;
         press_stamp = '0;
         expected_gestures.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IDLE_EXPIRE:  idle_expire = csr_wdata;
               CSR_REBOOT_HOLD:  reboot_hold = csr_wdata;
               CSR_FACTORY_HOLD: factory_hold = csr_wdata;
               default:          buttons_en = csr_wdata[0];
            endcase
         end

         // retire before predicting so a same-edge transaction is never taken
         if (rsp_valid && !rsp_stall) begin
            if (expected_gestures.size() == 0) begin
               $display("%0t: result transaction with nothing outstanding, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_gestures.pop_front();
               check_field("socket_toggle", want.socket_toggle, rsp_data.socket_toggle);
               check_field("reboot_request", want.reboot_request, rsp_data.reboot_request);
               check_field("reenable_buttons", want.reenable_buttons,
                           rsp_data.reenable_buttons);
               check_field("factory_reset_request", want.factory_reset_request,
                           rsp_data.factory_reset_request);
               check_field("reboot_armed_event", want.reboot_armed_event,
                           rsp_data.reboot_armed_event);
               check_field("factory_armed_event", want.factory_armed_event,
                           rsp_data.factory_armed_event);
               check_field("status_led_change", want.status_led_change,
                           rsp_data.status_led_change);
               check_field("status_flash_count", want.status_flash_count,
                           rsp_data.status_flash_count);
               check_field("wifi_flash_color", want.wifi_flash_color,
                           rsp_data.wifi_flash_color);
               check_field("reset_stage", want.reset_stage, rsp_data.reset_stage);
               results_checked++;
               if (want.socket_toggle != SOCKET_NONE || want.reboot_request ||
                   want.factory_reset_request)
                  gestures_seen++;
            end
         end

         if (req_valid && !req_stall)
            expected_gestures.push_back(evaluate_gesture(req_data));
      end
      pending = expected_gestures.size();
   end

endmodule

[bench/touch_button_gesture_fsm_tb.sv]
// ----------------------------------------------------------------------------
// touch_button_gesture_fsm_tb: testbench top for the touch gesture block
// Drives a directed gesture script, then well-formed double taps and center
// hold sequences mixed with noise, under six register settings, with bursty
// requests and patterned result back-pressure. Checking is in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module touch_button_gesture_fsm_tb;

   import tbg_pkg::*;

   localparam logic [1:0] ACT_UNSUPP = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = CSR_IDLE_EXPIRE;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending;
   int results_checked;
   int gestures_seen;

   int          sent_count;
   int          burst_left;
   int          cfg_reboot = REBOOT_HOLD_RESET;
   int          cfg_factory = FACTORY_HOLD_RESET;
   logic [31:0] t_ms;

   always #5 clock = ~clock;

   touch_button_gesture_fsm uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   touch_button_gesture_checker gesture_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending         (pending),
      .results_checked (results_checked),
      .gestures_seen   (gestures_seen)
   );

   // offer one transaction and hold it until accepted; sender works in bursts
   task automatic emit(input logic [1:0] action, input logic [1:0] button,
                       input logic [31:0] now);
      req_type item;
      int      gap;
      item.action = action;
      item.button = button;
      item.now_ms = now;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_BITS'(value);
      @(posedge clock);
   endtask

   task automatic configure(input int idle, input int reboot, input int factory,
                            input int btn_enable);
      drain();
      write_reg(CSR_IDLE_EXPIRE, idle);
      write_reg(CSR_REBOOT_HOLD, reboot);
      write_reg(CSR_FACTORY_HOLD, factory);
      write_reg(CSR_BUTTONS_EN, btn_enable);
      csr_wr_en <= 1'b0;
      cfg_reboot = reboot;
      cfg_factory = factory;
   endtask

   task automatic run_random(input int count);
      int          start_count;
      int          pick;
      int          k;
      int          n;
      int          depth;
      logic [31:0] t0;
      logic [31:0] now;
      logic [1:0]  btn;
      start_count = sent_count;
      while (sent_count - start_count < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            // double tap on A or B, occasionally too slow
            btn = ($urandom_range(0, 1) == 1) ? BTN_B : BTN_A;
            for (k = 0; k < 4; k++) begin
               t_ms += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000)
                                                   : $urandom_range(0, 400);
               emit(k[0] ? ACT_RELEASE : ACT_PRESS, btn, t_ms);
            end
         end else if (pick < 6) begin
            // triple tap center, press and hold, then release
            for (k = 0; k < 6; k++) begin
               t_ms += $urandom_range(0, 300);
               emit(k[0] ? ACT_RELEASE : ACT_PRESS, BTN_CENTER, t_ms);
            end
            t_ms += $urandom_range(0, 300);
            emit(ACT_PRESS, BTN_CENTER, t_ms);
            t0 = t_ms;
            depth = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1) begin
               // step to one ms short of each threshold, then onto it
               if (depth >= 1) begin
                  emit(ACT_TICK, BTN_A, t0 + cfg_reboot - 32'd1);
                  t_ms = t0 + cfg_reboot;
                  emit(ACT_TICK, BTN_A, t_ms);
               end
               if (depth == 2) begin
                  emit(ACT_TICK, BTN_B, t0 + STAGE_STEP_MS + cfg_factory - 32'd1);
                  t_ms = t0 + STAGE_STEP_MS + cfg_factory;
                  emit(ACT_TICK, BTN_B, t_ms);
               end
            end else begin
               n = $urandom_range(1, 5);
               for (k = 0; k < n; k++) begin
                  t_ms += $urandom_range(0, (cfg_reboot + cfg_factory + 2000) / 3);
                  emit(ACT_TICK, 2'($urandom_range(0, 3)), t_ms);
               end
            end
            t_ms += $urandom_range(0, 200);
            emit(ACT_RELEASE, BTN_CENTER, t_ms);
         end else if (pick == 6) begin
            // press one button, release a possibly different one
            t_ms += $urandom_range(0, 500);
            emit(ACT_PRESS, 2'($urandom_range(0, 3)), t_ms);
            t_ms += $urandom_range(0, 500);
            emit(ACT_RELEASE, 2'($urandom_range(0, 3)), t_ms);
         end else begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 3) == 0) begin
                  now = $urandom;
               end else begin
                  t_ms += $urandom_range(0, 2500);
                  now = t_ms;
               end
               emit(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), now);
            end
         end
      end
   endtask

   // result back-pressure in four random modes, plus a long hold-off
   initial begin : rsp_backpressure
      int cyc;
      int mode;
      int hold_left;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0)
            mode = $urandom_range(0, 3);
         if (cyc % 3000 == 700)
            hold_left = 120;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cyc[0];
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout: %0d transactions still outstanding", pending);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed script under reset register values
      emit(ACT_TICK, BTN_A, 32'd0);
      emit(ACT_UNSUPP, BTN_UNSUPP, 32'd1);
      emit(ACT_PRESS, BTN_UNSUPP, 32'd2);
      emit(ACT_PRESS, BTN_A, 32'd10);
      emit(ACT_RELEASE, BTN_A, 32'd50);
      emit(ACT_PRESS, BTN_A, 32'd100);
      emit(ACT_RELEASE, BTN_A, 32'd150);
      emit(ACT_PRESS, BTN_B, 32'd200);
      emit(ACT_RELEASE, BTN_B, 32'd250);
      emit(ACT_PRESS, BTN_B, 32'd300);
      emit(ACT_RELEASE, BTN_B, 32'd350);
      emit(ACT_RELEASE, BTN_A, 32'd400);
      emit(ACT_PRESS, BTN_CENTER, 32'd500);
      emit(ACT_RELEASE, BTN_CENTER, 32'd550);
      emit(ACT_PRESS, BTN_CENTER, 32'd600);
      emit(ACT_RELEASE, BTN_CENTER, 32'd650);
      emit(ACT_PRESS, BTN_CENTER, 32'd700);
      emit(ACT_RELEASE, BTN_CENTER, 32'd750);
      emit(ACT_PRESS, BTN_CENTER, 32'd800);
      emit(ACT_TICK, BTN_A, 32'd5800);
      emit(ACT_TICK, BTN_A, 32'd16800);
      emit(ACT_RELEASE, BTN_CENTER, 32'd16900);
      emit(ACT_TICK, BTN_UNSUPP, 32'hFFFF_FFFF);

      t_ms = 32'd20000;
      run_random(290);

      configure(0, 0, 0, 0);
      run_random(290);

      configure(65535, 65535, 65535, 1);
      run_random(290);

      // disabled buttons with immediate stage advances: reboot re-enables
      configure(65535, 0, 0, 0);
      run_random(290);

      // mid-range values, time base about to wrap
      configure($urandom_range(200, 4000), $urandom_range(200, 4000),
                $urandom_range(200, 4000), $urandom_range(0, 1));
      t_ms = 32'hFFFF_0000;
      run_random(290);

      configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 1));
      run_random(290);

      drain();
      $display("Summary: %0d transactions over six register settings, %0d results checked",
               sent_count, results_checked);
      $display("Summary: %0d socket toggles, reboot or factory reset requests predicted",
               gestures_seen);
      if (mismatch_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
